// File: sv/lmbr_pkg.sv
`default_nettype none

package lmbr_pkg;

   // register indexes on the configuration port
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_MIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_MAX      = 2'd2;

   // register reset values
   localparam logic [31:0] CHECK_INTERVAL_RST = 32'd5000;
   localparam logic [31:0] RETRY_MIN_RST      = 32'd5000;
   localparam logic [31:0] RETRY_MAX_RST      = 32'd300000;

   // link event codes
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_RESTORE = 2'd1;
   localparam logic [1:0] EV_LOSS    = 2'd2;

   typedef struct packed {
      logic [31:0] check_interval_ms;
      logic [31:0] retry_min_ms;
      logic [31:0] retry_max_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        link_up;
      logic        have_credentials;
      logic        clear_stats;
   } item_type;

   typedef struct packed {
      logic        reconnect_request;
      logic [1:0]  link_event;
      logic [31:0] disconnect_total;
      logic [31:0] uptime_ms;
      logic [31:0] downtime_ms;
      logic [31:0] last_loss_time;
      logic [31:0] last_restore_time;
      logic [31:0] current_retry_ms;
   } result_type;

   typedef struct packed {
      logic [31:0] last_check_time;
      logic [31:0] retry_delay;
      logic        prev_link_up;
      logic [31:0] up_since;
      logic [31:0] down_since;
      logic        up_running;
      logic        down_running;
      logic [31:0] last_attempt_time;
      logic [31:0] loss_count;
      logic [31:0] uptime_acc;
      logic [31:0] downtime_acc;
      logic [31:0] loss_stamp;
      logic [31:0] restore_stamp;
   } state_type;

endpackage

`default_nettype wire

// File: sv/lmbr_req_if.sv
`default_nettype none

interface lmbr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        link_up;
   logic        have_credentials;
   logic        clear_stats;

   modport source (output valid, now_ms, link_up, have_credentials, clear_stats,
                   input ready);
   modport sink   (input valid, now_ms, link_up, have_credentials, clear_stats,
                   output ready);
endinterface

`default_nettype wire

// File: sv/lmbr_rsp_if.sv
`default_nettype none

interface lmbr_rsp_if;
   logic        valid;
   logic        ready;
   logic        reconnect_request;
   logic [1:0]  link_event;
   logic [31:0] disconnect_total;
   logic [31:0] uptime_ms;
   logic [31:0] downtime_ms;
   logic [31:0] last_loss_time;
   logic [31:0] last_restore_time;
   logic [31:0] current_retry_ms;

   modport source (output valid, reconnect_request, link_event, disconnect_total,
                          uptime_ms, downtime_ms, last_loss_time, last_restore_time,
                          current_retry_ms,
                   input ready);
   modport sink   (input valid, reconnect_request, link_event, disconnect_total,
                         uptime_ms, downtime_ms, last_loss_time, last_restore_time,
                         current_retry_ms,
                   output ready);
endinterface

`default_nettype wire

// File: sv/lmbr_csr_if.sv
`default_nettype none

interface lmbr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/lmbr_csr_regs.sv
`default_nettype none

module lmbr_csr_regs (
   input  wire logic          clock,
   input  wire logic          reset,
   lmbr_csr_if.sink           csr_in,
   output lmbr_pkg::cfg_type  cfg
);
   import lmbr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_in.ready = 1'b1;
   assign cfg          = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_in.valid) begin
         unique case (csr_in.index)
            CSR_CHECK_INTERVAL: cfg_in.check_interval_ms = csr_in.data;
            CSR_RETRY_MIN:      cfg_in.retry_min_ms      = csr_in.data;
            CSR_RETRY_MAX:      cfg_in.retry_max_ms      = csr_in.data;
            default:            cfg_in                   = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_interval_ms <= CHECK_INTERVAL_RST;
         cfg_ff.retry_min_ms      <= RETRY_MIN_RST;
         cfg_ff.retry_max_ms      <= RETRY_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

`default_nettype wire

// File: sv/lmbr_step.sv
`default_nettype none

module lmbr_step (
   input  wire lmbr_pkg::item_type   item,
   input  wire lmbr_pkg::state_type  state,
   input  wire lmbr_pkg::cfg_type    cfg,
   output lmbr_pkg::state_type       state_next,
   output lmbr_pkg::result_type      result
);
   import lmbr_pkg::*;

   always_comb begin
      state_type   s;
      logic        due;
      logic        attempt;
      logic [32:0] doubled;
      logic [31:0] up_out;
      logic [31:0] down_out;

      s        = state;
      result   = '0;
      attempt  = 1'b0;

      // clear of statistics goes first
      if (item.clear_stats) begin
         s.loss_count    = '0;
         s.uptime_acc    = '0;
         s.downtime_acc  = '0;
         s.loss_stamp    = '0;
         s.restore_stamp = '0;
      end

      due     = (item.now_ms - state.last_check_time) >= cfg.check_interval_ms;
      doubled = {state.retry_delay, 1'b0};

      if (due) begin
         s.last_check_time = item.now_ms;
         // link edges
         if (item.link_up && !state.prev_link_up) begin
            result.link_event = EV_RESTORE;
            s.restore_stamp   = item.now_ms;
            if (state.down_running) begin
               s.downtime_acc = s.downtime_acc + (item.now_ms - state.down_since);
            end
            s.down_running = 1'b0;
            s.down_since   = '0;
            s.up_since     = item.now_ms;
            s.up_running   = 1'b1;
            s.retry_delay  = cfg.retry_min_ms;
         end else if (!item.link_up && state.prev_link_up) begin
            result.link_event = EV_LOSS;
            s.loss_count      = s.loss_count + 32'd1;
            s.loss_stamp      = item.now_ms;
            if (state.up_running) begin
               s.uptime_acc = s.uptime_acc + (item.now_ms - state.up_since);
            end
            s.up_running   = 1'b0;
            s.up_since     = '0;
            s.down_since   = item.now_ms;
            s.down_running = 1'b1;
         end
         s.prev_link_up = item.link_up;

         // reconnect with doubling backoff, a restore never coincides with it
         attempt = !item.link_up && item.have_credentials &&
                   ((item.now_ms - state.last_attempt_time) >= state.retry_delay);
         if (attempt) begin
            s.last_attempt_time = item.now_ms;
            if (doubled > {1'b0, cfg.retry_max_ms}) begin
               s.retry_delay = cfg.retry_max_ms;
            end else begin
               s.retry_delay = doubled[31:0];
            end
         end
      end

      // live intervals folded into the reported totals
      up_out   = s.uptime_acc;
      down_out = s.downtime_acc;
      if (s.prev_link_up && s.up_running) begin
         up_out = s.uptime_acc + (item.now_ms - s.up_since);
      end
      if (!s.prev_link_up && s.down_running) begin
         down_out = s.downtime_acc + (item.now_ms - s.down_since);
      end

      result.reconnect_request = attempt;
      result.disconnect_total  = s.loss_count;
      result.uptime_ms         = up_out;
      result.downtime_ms       = down_out;
      result.last_loss_time    = s.loss_stamp;
      result.last_restore_time = s.restore_stamp;
      result.current_retry_ms  = s.retry_delay;

      state_next = s;
   end
endmodule

`default_nettype wire

// File: sv/link_monitor_backoff_retry_core.sv
`default_nettype none

// an accepted request beat passes through the input register and the result register to its response beat
// throughput: one item per cycle while the response side is ready, set by the combinational state update step
// reset: synchronous, clears pipeline valids, monitor state and loads register defaults
// configuration writes take effect the cycle after the write beat
module link_monitor_backoff_retry_core (
   input  wire logic  clock,
   input  wire logic  reset,
   lmbr_req_if.sink   req_in,
   lmbr_rsp_if.source rsp_out,
   lmbr_csr_if.sink   csr_in
);
   import lmbr_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       stage_valid_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       out_valid_ff;
   logic       advance;

   // configuration registers
   lmbr_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_in (csr_in),
      .cfg    (cfg)
   );

   // monitor step on the registered item
   lmbr_step u_step (
      .item       (item_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .result     (result_in)
   );

   // pipeline handshake
   assign advance      = stage_valid_ff && (!out_valid_ff || rsp_out.ready);
   assign req_in.ready = !stage_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_in.ready) begin
         stage_valid_ff <= req_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_in.valid && req_in.ready) begin
         item_ff.now_ms           <= req_in.now_ms;
         item_ff.link_up          <= req_in.link_up;
         item_ff.have_credentials <= req_in.have_credentials;
         item_ff.clear_stats      <= req_in.clear_stats;
      end
   end

   // monitor state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{retry_delay: RETRY_MIN_RST, default: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_out.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_out.valid             = out_valid_ff;
   assign rsp_out.reconnect_request = result_ff.reconnect_request;
   assign rsp_out.link_event        = result_ff.link_event;
   assign rsp_out.disconnect_total  = result_ff.disconnect_total;
   assign rsp_out.uptime_ms         = result_ff.uptime_ms;
   assign rsp_out.downtime_ms       = result_ff.downtime_ms;
   assign rsp_out.last_loss_time    = result_ff.last_loss_time;
   assign rsp_out.last_restore_time = result_ff.last_restore_time;
   assign rsp_out.current_retry_ms  = result_ff.current_retry_ms;
endmodule

`default_nettype wire
